// File: rtl/rtlpm_pkg.sv
// Shared types and codes for the IPv4 route table with longest-prefix lookup.
package rtlpm_pkg;

  // Operation codes carried by an input transaction.
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_EXISTS      = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [2:0] ST_NO_ROUTE    = 3'd5;
  localparam logic [2:0] ST_DEFAULT_DEV = 3'd6;

  // Top nibble of a multicast address; every nibble at or above it is not unicast.
  localparam logic [3:0] MCAST_NIBBLE = 4'hE;

  // Width of the device enable register.
  localparam int DEV_MASK_W = 8;

  // One input transaction.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] netmask;
    logic [31:0] gateway;
    logic [2:0]  device_index;
    logic [15:0] metric;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_network;
    logic [31:0] out_netmask;
    logic [31:0] out_gateway;
    logic [2:0]  out_device;
    logic [15:0] out_metric;
  } out_item_t;

  // One stored route.
  typedef struct packed {
    logic [31:0] network;
    logic [31:0] netmask;
    logic [31:0] gateway;
    logic [2:0]  device;
    logic [15:0] metric;
  } entry_t;

  // Per-slot compare outcome from the shared match unit.
  typedef struct packed {
    logic exact_hit;
    logic route_hit;
    logic better;
  } match_t;

endpackage

// File: rtl/rtlpm_match_unit.sv
// Shared compare unit that scores one stored route against the current request.
module rtlpm_match_unit (
  input  logic [31:0]                       req_addr,
  input  logic [31:0]                       key_net,
  input  logic [31:0]                       req_mask,
  input  logic [2:0]                        req_dev,
  input  rtlpm_pkg::entry_t                 entry,
  input  logic                              entry_valid,
  input  logic [rtlpm_pkg::DEV_MASK_W-1:0]  dev_enable,
  input  logic                              best_found,
  input  logic [31:0]                       best_mask,
  input  logic [15:0]                       best_metric,
  output rtlpm_pkg::match_t                 result
);
  import rtlpm_pkg::*;

  logic route_hit;
  logic longer;
  logic same_len_cheaper;

  // A lookup hit needs a live entry on an enabled device whose prefix covers the destination.
  assign route_hit = entry_valid && dev_enable[entry.device] &&
                     ((req_addr & entry.netmask) == entry.network);

  // Masks are contiguous, so a numerically larger mask is a longer prefix.
  assign longer           = entry.netmask > best_mask;
  assign same_len_cheaper = (entry.netmask == best_mask) && (entry.metric < best_metric);

  // Exact match on device, masked network and mask for add and remove.
  assign result.exact_hit = entry_valid && (entry.device == req_dev) &&
                            (entry.network == key_net) && (entry.netmask == req_mask);
  assign result.route_hit = route_hit;
  assign result.better    = route_hit && (!best_found || longer || same_len_cheaper);

endmodule

// File: rtl/ipv4_route_table_lpm_core.sv
// Top level of the IPv4 route table: sequencer, slot memory and result register.
// A scanned operation passes through the check, scan, drain and finish states before its
// result is strobed. A new transaction is accepted only while idle, and the scan reads
// one slot per cycle through the single read port of the slot memory and the shared match unit.
// A rejected request (bad mask, device, gateway or destination) is strobed from the check state.
// Synchronous active-low reset empties the table and enables all devices; results cannot stall.
module ipv4_route_table_lpm_core #(
  parameter int ROUTE_SLOTS  = 16,
  parameter int DEVICE_COUNT = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rtlpm_pkg::in_item_t              in_item,
  output logic                             out_strobe,
  output rtlpm_pkg::out_item_t             out_item,
  input  logic                             cfg_we,
  input  logic [rtlpm_pkg::DEV_MASK_W-1:0] cfg_wdata
);
  import rtlpm_pkg::*;

  localparam int IDXW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Request and configuration registers.
  in_item_t              req_r;
  logic [31:0]           key_net_r;
  logic [DEV_MASK_W-1:0] enable_r;

  // Slot storage.
  logic [ROUTE_SLOTS-1:0] valid_r;
  entry_t                 mem [ROUTE_SLOTS];
  entry_t                 rd_data_r;

  // Scan pipeline.
  logic [IDXW-1:0] scan_idx_r;
  logic            proc_v_r;
  logic [IDXW-1:0] proc_idx_r;

  // Scan trackers.
  logic            hit_found_r;
  logic [IDXW-1:0] hit_idx_r;
  logic            free_found_r;
  logic [IDXW-1:0] free_idx_r;
  logic            best_found_r;
  entry_t          best_r;

  // Result register.
  logic      out_strobe_r;
  out_item_t out_item_r;

  // Request checks.
  logic [31:0] inv_mask;
  logic        mask_contig;
  logic        dev_in_range;
  logic        dev_enabled;
  logic        gw_ok;
  logic        addr_multi;
  logic        addr_bcast;
  logic        addr_unicast;
  logic        early_done;
  logic [2:0]  early_status;

  // Finish step.
  logic        mem_we;
  entry_t      mem_wdata;
  logic [2:0]  fin_status;
  logic        fin_set_valid;
  logic        fin_clr_valid;

  match_t      match;
  logic        proc_valid;
  logic        scan_last;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;
  assign proc_valid = valid_r[proc_idx_r];
  assign scan_last  = (scan_idx_r == IDXW'(ROUTE_SLOTS - 1));

  // Validate the latched request; a contiguous mask has ~m of the form 0..01..1.
  assign inv_mask     = ~req_r.netmask;
  assign mask_contig  = ((inv_mask & (inv_mask + 32'd1)) == 32'd0);
  assign dev_in_range = ({1'b0, req_r.device_index} < 4'(DEVICE_COUNT));
  assign dev_enabled  = dev_in_range && enable_r[req_r.device_index];
  assign gw_ok        = (req_r.gateway == 32'd0) || (req_r.gateway[31:28] < MCAST_NIBBLE);
  assign addr_multi   = (req_r.address[31:28] == MCAST_NIBBLE);
  assign addr_bcast   = &req_r.address;
  assign addr_unicast = (req_r.address != 32'd0) && (req_r.address[31:28] < MCAST_NIBBLE);

  always_comb begin
    early_done   = 1'b0;
    early_status = ST_INVALID;
    case (req_r.opcode)
      OP_ADD: begin
        early_done = !(mask_contig && dev_enabled && gw_ok);
      end
      OP_REMOVE: begin
        early_done = !(mask_contig && dev_in_range);
      end
      OP_LOOKUP: begin
        if (addr_multi || addr_bcast) begin
          early_done   = 1'b1;
          early_status = ST_DEFAULT_DEV;
        end else if (!addr_unicast) begin
          early_done = 1'b1;
        end
      end
      default: begin
        early_done = 1'b1;
      end
    endcase
  end

  // Shared compare unit, fed one slot per cycle.
  rtlpm_match_unit u_match (
    .req_addr    (req_r.address),
    .key_net     (key_net_r),
    .req_mask    (req_r.netmask),
    .req_dev     (req_r.device_index),
    .entry       (rd_data_r),
    .entry_valid (proc_valid),
    .dev_enable  (enable_r),
    .best_found  (best_found_r),
    .best_mask   (best_r.netmask),
    .best_metric (best_r.metric),
    .result      (match)
  );

  // Outcome of a scanned operation and the table update it commits.
  always_comb begin
    mem_we        = 1'b0;
    fin_set_valid = 1'b0;
    fin_clr_valid = 1'b0;
    fin_status    = ST_INVALID;
    mem_wdata     = '{network: key_net_r, netmask: req_r.netmask, gateway: req_r.gateway,
                      device: req_r.device_index, metric: req_r.metric};
    case (req_r.opcode)
      OP_ADD: begin
        if (hit_found_r) begin
          fin_status = ST_EXISTS;
        end else if (free_found_r) begin
          fin_status    = ST_OK;
          mem_we        = (state_r == S_FINISH);
          fin_set_valid = (state_r == S_FINISH);
        end else begin
          fin_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit_found_r) begin
          fin_status    = ST_OK;
          fin_clr_valid = (state_r == S_FINISH);
        end else begin
          fin_status = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        fin_status = best_found_r ? ST_OK : ST_NO_ROUTE;
      end
      default: begin
        fin_status = ST_INVALID;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = early_done ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx_r] <= mem_wdata;
    end
    rd_data_r <= mem[scan_idx_r];
  end

  // Valid bits and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      enable_r <= '1;
    end else begin
      if (cfg_we) enable_r <= cfg_wdata;
      if (fin_set_valid) valid_r[free_idx_r] <= 1'b1;
      if (fin_clr_valid) valid_r[hit_idx_r] <= 1'b0;
    end
  end

  // Request capture on an accepted transaction.
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      req_r <= in_item;
    end
    if (state_r == S_CHECK) begin
      key_net_r <= req_r.address & req_r.netmask;
    end
  end

  // Scan address counter and the processing stage behind the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      proc_v_r   <= 1'b0;
      proc_idx_r <= '0;
    end else begin
      proc_v_r   <= (state_r == S_SCAN);
      proc_idx_r <= scan_idx_r;
      if (state_r == S_SCAN) begin
        scan_idx_r <= scan_last ? '0 : scan_idx_r + IDXW'(1);
      end else begin
        scan_idx_r <= '0;
      end
    end
  end

  // Trackers: first exact hit, first free slot and best lookup route so far.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
      hit_idx_r    <= '0;
      free_idx_r   <= '0;
    end else if (state_r == S_CHECK) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (proc_v_r) begin
      if (match.exact_hit && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= proc_idx_r;
      end
      if (!proc_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= proc_idx_r;
      end
      if (match.better) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_v_r && match.better) begin
      best_r <= rd_data_r;
    end
  end

  // Result register: one strobed transaction per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ((state_r == S_CHECK) && early_done) || (state_r == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      out_item_r <= '{status: early_status, default: '0};
    end else if (state_r == S_FINISH) begin
      if ((req_r.opcode == OP_LOOKUP) && best_found_r) begin
        out_item_r <= '{status: fin_status, out_network: best_r.network,
                        out_netmask: best_r.netmask, out_gateway: best_r.gateway,
                        out_device: best_r.device, out_metric: best_r.metric};
      end else begin
        out_item_r <= '{status: fin_status, default: '0};
      end
    end
  end

endmodule
